FILE: rtl/rrfl_pkg.sv
// Package for the register rename free list unit: widths, function codes,
// free ring pointer helpers. No dependencies.
`timescale 1ns / 1ps

package rrfl_pkg;

    localparam int PHYS_REGS = 256;
    localparam int ARCH_REGS = 50;
    localparam int FLAGS_REG = 49;

    localparam int PHYS_W    = 8;
    localparam int ARCH_W    = 6;
    localparam int FUNC_W    = 2;
    localparam int RING_AW   = $clog2(PHYS_REGS);
    localparam int CNT_W     = $clog2(PHYS_REGS + 1);
    // Map RAM holds registers 0..48; flags register lives in a flop
    localparam int MAP_DEPTH = ARCH_REGS - 1;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    typedef logic [PHYS_W-1:0]  t_phys;
    typedef logic [ARCH_W-1:0]  t_arch;
    typedef logic [RING_AW-1:0] t_ring_ptr;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [MAP_AW-1:0]  t_map_addr;
    typedef logic [FUNC_W-1:0]  t_func;

    localparam t_func FUNC_RENAME = 2'd0;
    localparam t_func FUNC_COMMIT = 2'd1;
    localparam t_func FUNC_UNDO   = 2'd2;

    localparam t_arch  ARCH_FLAGS = t_arch'(FLAGS_REG);
    localparam t_arch  ARCH_LIMIT = t_arch'(ARCH_REGS);
    localparam t_count CNT_FULL   = t_count'(PHYS_REGS);

    function automatic t_ring_ptr ring_inc(input t_ring_ptr ptr);
        return (ptr == t_ring_ptr'(PHYS_REGS - 1)) ? '0 : ptr + 1'b1;
    endfunction

    function automatic t_ring_ptr ring_dec(input t_ring_ptr ptr);
        return (ptr == '0) ? t_ring_ptr'(PHYS_REGS - 1) : ptr - 1'b1;
    endfunction

    // Reset content of a ring slot: slot i holds register i + 50
    function automatic t_phys ring_init(input t_ring_ptr idx);
        return t_phys'(32'(idx) + ARCH_REGS);
    endfunction

    // Map RAM address of an architectural register below the flags register
    function automatic t_map_addr map_addr(input t_arch arch);
        return (arch < ARCH_FLAGS) ? arch[MAP_AW-1:0] : '0;
    endfunction

endpackage

FILE: rtl/register_rename_free_list_unit.sv
// Register rename unit top level: map table RAM, flags mapping flop, free ring RAM.
// Depends on rrfl_pkg and rrfl_ram.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -------------------------------------
//  in        to block   i_in_valid / o_in_stall    i_func, sources, dest, flags, phys_a/b
//  out       from block o_out_valid / i_out_stall  source and dest mappings, status, count
//
//  Each transaction steps from acceptance through three reads on the single map
//  RAM read port (src1, src2, dest), an execute step, a step for the second free
//  ring write, and a step that loads the result into the output register.
//  Reset clears the RAM valid bits; no clearing pass is needed.
//  A stalled result holds in the output register while the next transaction runs;
//  that transaction waits in its last step until the output register frees.

module register_rename_free_list_unit
    import rrfl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,

    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_func,
    input  logic          i_src1_valid,
    input  logic [5:0]    i_src1_arch,
    input  logic          i_src2_valid,
    input  logic [5:0]    i_src2_arch,
    input  logic          i_reads_flags,
    input  logic          i_dest_valid,
    input  logic [5:0]    i_dest_arch,
    input  logic          i_writes_flags,
    input  logic [7:0]    i_phys_a,
    input  logic [7:0]    i_phys_b,

    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_phys_src1,
    output logic [7:0]    o_phys_src2,
    output logic [7:0]    o_phys_flags_src,
    output logic [7:0]    o_new_dest,
    output logic [7:0]    o_new_flags_dest,
    output logic [7:0]    o_prev_dest,
    output logic [7:0]    o_prev_flags,
    output logic          o_status,
    output logic [8:0]    o_free_count
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;   // read src1 mapping, ring head
    localparam logic [2:0] S_RDB  = 3'd2;   // read src2 mapping, ring head + 1
    localparam logic [2:0] S_RDC  = 3'd3;   // read dest mapping
    localparam logic [2:0] S_EXEC = 3'd4;   // update map, pop or first push
    localparam logic [2:0] S_WR2  = 3'd5;   // second push
    localparam logic [2:0] S_DONE = 3'd6;   // load output register

    logic [2:0]      r_state, n_state;

    // Captured transaction
    t_func           r_func,   n_func;
    logic            r_s1v,    n_s1v;
    t_arch           r_s1,     n_s1;
    logic            r_s2v,    n_s2v;
    t_arch           r_s2,     n_s2;
    logic            r_rf,     n_rf;
    logic            r_dv,     n_dv;
    t_arch           r_d,      n_d;
    logic            r_wf,     n_wf;
    t_phys           r_pa,     n_pa;
    t_phys           r_pb,     n_pb;

    // Rename state outside the RAMs
    t_phys           r_flags_map, n_flags_map;
    logic [MAP_DEPTH-1:0] r_map_vld;
    logic [PHYS_REGS-1:0] r_ring_vld;
    t_ring_ptr       r_head,   n_head;
    t_ring_ptr       r_tail,   n_tail;
    t_count          r_count,  n_count;

    // Read-side tags, registered with the RAM read
    logic            r_mq_vld;
    t_map_addr       r_mq_idx;
    logic            r_rq_vld;
    t_ring_ptr       r_rq_idx;
    t_phys           r_pop0,   n_pop0;
    t_phys           r_pop1,   n_pop1;

    // Working results
    t_phys           r_src1,   n_src1;
    t_phys           r_src2,   n_src2;
    t_phys           r_fsrc,   n_fsrc;
    t_phys           r_ndst,   n_ndst;
    t_phys           r_nflg,   n_nflg;
    t_phys           r_pdst,   n_pdst;
    t_phys           r_pflg,   n_pflg;
    logic            r_stat,   n_stat;
    logic            r_p1_vld, n_p1_vld;
    t_phys           r_p1_val, n_p1_val;

    // Output register
    logic            r_out_valid, n_out_valid;
    t_phys           r_o_src1, r_o_src2, r_o_fsrc, r_o_ndst, r_o_nflg, r_o_pdst, r_o_pflg;
    logic            r_o_stat;
    t_count          r_o_cnt;
    logic            out_load;

    // RAM ports
    logic            map_we, map_re;
    t_map_addr       map_waddr, map_raddr;
    t_phys           map_wdata, map_rdata;
    logic            ring_we, ring_re;
    t_ring_ptr       ring_waddr, ring_raddr;
    t_phys           ring_wdata, ring_rdata;

    // Push request for the current cycle
    logic            push_v;
    t_phys           push_val;
    logic            push_head;
    logic            push_ok;

    logic            in_accept;
    t_phys           map_val;
    t_phys           ring_val;
    t_phys           cur_d;
    t_phys           pop_f;
    logic [1:0]      need;

    rrfl_ram #(.WIDTH(PHYS_W), .DEPTH(MAP_DEPTH)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    rrfl_ram #(.WIDTH(PHYS_W), .DEPTH(PHYS_REGS)) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Entries never written read as their reset contents
    assign map_val  = r_mq_vld ? map_rdata : t_phys'(r_mq_idx);
    assign ring_val = r_rq_vld ? ring_rdata : ring_init(r_rq_idx);

    // Current mapping of the destination; the flags register sits in a flop
    assign cur_d = (r_d == ARCH_FLAGS) ? r_flags_map : map_val;
    assign pop_f = r_dv ? r_pop1 : r_pop0;
    assign need  = {1'b0, r_dv} + {1'b0, r_wf};

    assign push_head  = (r_func == FUNC_UNDO);
    assign push_ok    = push_v && (r_count < CNT_FULL);
    assign ring_we    = push_ok;
    assign ring_waddr = push_head ? ring_dec(r_head) : r_tail;
    assign ring_wdata = push_val;

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Source lookup: absent or out of range reads zero
    function automatic t_phys src_lookup(input logic v, input t_arch arch,
                                         input t_phys flags, input t_phys ram_val);
        t_phys res;
        res = '0;
        if (v && arch == ARCH_FLAGS) begin
            res = flags;
        end else if (v && arch < ARCH_FLAGS) begin
            res = ram_val;
        end
        return res;
    endfunction

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_s1v       = r_s1v;
        n_s1        = r_s1;
        n_s2v       = r_s2v;
        n_s2        = r_s2;
        n_rf        = r_rf;
        n_dv        = r_dv;
        n_d         = r_d;
        n_wf        = r_wf;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_flags_map = r_flags_map;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pop0      = r_pop0;
        n_pop1      = r_pop1;
        n_src1      = r_src1;
        n_src2      = r_src2;
        n_fsrc      = r_fsrc;
        n_ndst      = r_ndst;
        n_nflg      = r_nflg;
        n_pdst      = r_pdst;
        n_pflg      = r_pflg;
        n_stat      = r_stat;
        n_p1_vld    = r_p1_vld;
        n_p1_val    = r_p1_val;
        n_out_valid = r_out_valid && i_out_stall;

        map_we      = 1'b0;
        map_waddr   = map_addr(r_d);
        map_wdata   = r_pa;
        map_re      = 1'b0;
        map_raddr   = '0;
        ring_re     = 1'b0;
        ring_raddr  = r_head;
        push_v      = 1'b0;
        push_val    = r_pa;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_func  = i_func;
                    n_s1v   = i_src1_valid;
                    n_s1    = i_src1_arch;
                    n_s2v   = i_src2_valid;
                    n_s2    = i_src2_arch;
                    n_rf    = i_reads_flags;
                    // Drop a destination outside the architectural range
                    n_dv    = i_dest_valid && (i_dest_arch < ARCH_LIMIT);
                    n_d     = i_dest_arch;
                    n_wf    = i_writes_flags;
                    n_pa    = i_phys_a;
                    n_pb    = i_phys_b;
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                map_re     = 1'b1;
                map_raddr  = map_addr(r_s1);
                ring_re    = 1'b1;
                ring_raddr = r_head;
                n_state    = S_RDB;
            end
            S_RDB: begin
                n_src1     = src_lookup(r_s1v, r_s1, r_flags_map, map_val);
                n_pop0     = ring_val;
                map_re     = 1'b1;
                map_raddr  = map_addr(r_s2);
                ring_re    = 1'b1;
                ring_raddr = ring_inc(r_head);
                n_state    = S_RDC;
            end
            S_RDC: begin
                n_src2    = src_lookup(r_s2v, r_s2, r_flags_map, map_val);
                n_pop1    = ring_val;
                map_re    = 1'b1;
                map_raddr = map_addr(r_d);
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                n_fsrc   = '0;
                n_ndst   = '0;
                n_nflg   = '0;
                n_pdst   = '0;
                n_pflg   = '0;
                n_stat   = 1'b0;
                n_p1_vld = 1'b0;
                n_p1_val = r_pb;
                unique case (r_func)
                    FUNC_RENAME: begin
                        n_fsrc = r_rf ? r_flags_map : '0;
                        if (r_count < t_count'(need)) begin
                            // Refuse: free list too short, leave state alone
                            n_stat = 1'b1;
                        end else begin
                            if (r_dv) begin
                                n_ndst    = r_pop0;
                                n_pdst    = cur_d;
                                map_wdata = r_pop0;
                                if (r_d == ARCH_FLAGS) begin
                                    n_flags_map = r_pop0;
                                end else begin
                                    map_we = 1'b1;
                                end
                            end
                            if (r_wf) begin
                                n_nflg      = pop_f;
                                n_pflg      = (r_dv && r_d == ARCH_FLAGS) ? r_pop0
                                                                          : r_flags_map;
                                n_flags_map = pop_f;
                            end
                            if (r_dv && r_wf) begin
                                n_head = ring_inc(ring_inc(r_head));
                            end else if (r_dv || r_wf) begin
                                n_head = ring_inc(r_head);
                            end
                            n_count = r_count - t_count'(need);
                        end
                    end
                    FUNC_COMMIT: begin
                        n_src1   = '0;
                        n_src2   = '0;
                        push_v   = r_dv;
                        push_val = r_pa;
                        n_p1_vld = r_wf;
                        n_p1_val = r_pb;
                    end
                    FUNC_UNDO: begin
                        n_src1 = '0;
                        n_src2 = '0;
                        if (r_dv) begin
                            // Restore the prior mapping, return the current one
                            map_wdata = r_pa;
                            if (r_d == ARCH_FLAGS) begin
                                n_flags_map = r_pa;
                            end else begin
                                map_we = 1'b1;
                            end
                            push_v   = 1'b1;
                            push_val = cur_d;
                        end
                        if (r_wf) begin
                            n_p1_vld    = 1'b1;
                            n_p1_val    = (r_dv && r_d == ARCH_FLAGS) ? r_pa : r_flags_map;
                            n_flags_map = r_pb;
                        end
                    end
                    default: begin
                        n_src1 = '0;
                        n_src2 = '0;
                    end
                endcase
                n_state = S_WR2;
            end
            S_WR2: begin
                push_v   = r_p1_vld;
                push_val = r_p1_val;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Apply an accepted push; a full list drops it
        if (push_ok) begin
            if (push_head) begin
                n_head = ring_dec(r_head);
            end else begin
                n_tail = ring_inc(r_tail);
            end
            n_count = r_count + 1'b1;
        end
    end

    // Control and rename state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flags_map <= t_phys'(FLAGS_REG);
            r_map_vld   <= '0;
            r_ring_vld  <= '0;
            r_head      <= '0;
            r_tail      <= t_ring_ptr'(PHYS_REGS - ARCH_REGS);
            r_count     <= t_count'(PHYS_REGS - ARCH_REGS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flags_map <= n_flags_map;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (map_we) begin
                r_map_vld[map_waddr] <= 1'b1;
            end
            if (ring_we) begin
                r_ring_vld[ring_waddr] <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_s1v    <= n_s1v;
        r_s1     <= n_s1;
        r_s2v    <= n_s2v;
        r_s2     <= n_s2;
        r_rf     <= n_rf;
        r_dv     <= n_dv;
        r_d      <= n_d;
        r_wf     <= n_wf;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_pop0   <= n_pop0;
        r_pop1   <= n_pop1;
        r_src1   <= n_src1;
        r_src2   <= n_src2;
        r_fsrc   <= n_fsrc;
        r_ndst   <= n_ndst;
        r_nflg   <= n_nflg;
        r_pdst   <= n_pdst;
        r_pflg   <= n_pflg;
        r_stat   <= n_stat;
        r_p1_vld <= n_p1_vld;
        r_p1_val <= n_p1_val;
        // Tag each RAM read with the slot's valid bit and index
        if (map_re) begin
            r_mq_vld <= r_map_vld[map_raddr];
            r_mq_idx <= map_raddr;
        end
        if (ring_re) begin
            r_rq_vld <= r_ring_vld[ring_raddr];
            r_rq_idx <= ring_raddr;
        end
        if (out_load) begin
            r_o_src1 <= r_src1;
            r_o_src2 <= r_src2;
            r_o_fsrc <= r_fsrc;
            r_o_ndst <= r_ndst;
            r_o_nflg <= r_nflg;
            r_o_pdst <= r_pdst;
            r_o_pflg <= r_pflg;
            r_o_stat <= r_stat;
            r_o_cnt  <= r_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_phys_src1      = r_o_src1;
    assign o_phys_src2      = r_o_src2;
    assign o_phys_flags_src = r_o_fsrc;
    assign o_new_dest       = r_o_ndst;
    assign o_new_flags_dest = r_o_nflg;
    assign o_prev_dest      = r_o_pdst;
    assign o_prev_flags     = r_o_pflg;
    assign o_status         = r_o_stat;
    assign o_free_count     = r_o_cnt;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("free count above ring size");

    a_ptrs_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_FULL || r_count == '0) |-> (r_head == r_tail))
        else $error("ring pointers disagree with free count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input taken while a transaction is in flight");

    a_refuse_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_func == FUNC_RENAME && n_stat) |=>
            (r_count == $past(r_count) && r_head == $past(r_head)))
        else $error("refused rename changed the free list");
`endif

endmodule

FILE: rtl/rrfl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module rrfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: bench/register_rename_free_list_unit_tb.sv
// Self-checking bench for register_rename_free_list_unit: directed table, then random
// drain/fill/mixed phases, each result checked against a map table and free ring predictor.
// Depends on rrfl_pkg and the RTL of the block.
`timescale 1ns / 1ps

module register_rename_free_list_unit_tb;
    import rrfl_pkg::*;

    // Codes that the package does not name
    localparam t_func FUNC_UNUSED = 2'd3;
    localparam logic  STAT_DONE   = 1'b0;
    localparam logic  STAT_SHORT  = 1'b1;

    // Stimulus phases of the random part
    localparam int MODE_DRAIN = 0;  // mostly renames: run the free list dry
    localparam int MODE_FILL  = 1;  // mostly commits: push the free list to full
    localparam int MODE_MIX   = 2;  // balanced traffic
    localparam int PHASE_LEN  = 212;
    localparam int QUIET_PHASE = 4; // phase with no idling on either side
    localparam int IDLE_PCT   = 28;
    localparam int MAX_INFLIGHT = 96;
    localparam int MAX_REPORTS = 10;

    // One micro-op as presented on the input channel
    typedef struct packed {
        t_func func;
        logic  s1v;
        t_arch s1;
        logic  s2v;
        t_arch s2;
        logic  rf;
        logic  dv;
        t_arch d;
        logic  wf;
        t_phys pa;
        t_phys pb;
    } t_uop;

    // One rename result as seen on the output channel
    typedef struct packed {
        t_phys  src1;
        t_phys  src2;
        t_phys  flags_src;
        t_phys  new_dest;
        t_phys  new_flags;
        t_phys  prev_dest;
        t_phys  prev_flags;
        logic   status;
        t_count free_cnt;
    } t_rename_res;

    // Directed row: expectation typed in only where it is obvious
    typedef struct packed {
        t_uop        op;
        logic        typed;
        t_rename_res res;
    } t_dir_row;

    // Renamed micro-op not yet committed or undone; feeds well-formed commits/undos
    typedef struct packed {
        logic  dv;
        logic  wf;
        t_arch d;
        t_phys prev_dest;
        t_phys prev_flags;
    } t_inflight;

    localparam t_rename_res NO_RES = '0;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_stall;
    logic [1:0]   i_func;
    logic         i_src1_valid;
    logic [5:0]   i_src1_arch;
    logic         i_src2_valid;
    logic [5:0]   i_src2_arch;
    logic         i_reads_flags;
    logic         i_dest_valid;
    logic [5:0]   i_dest_arch;
    logic         i_writes_flags;
    logic [7:0]   i_phys_a;
    logic [7:0]   i_phys_b;
    logic         o_out_valid;
    logic         i_out_stall;
    logic [7:0]   o_phys_src1;
    logic [7:0]   o_phys_src2;
    logic [7:0]   o_phys_flags_src;
    logic [7:0]   o_new_dest;
    logic [7:0]   o_new_flags_dest;
    logic [7:0]   o_prev_dest;
    logic [7:0]   o_prev_flags;
    logic         o_status;
    logic [8:0]   o_free_count;

    // Predictor state: architectural map and the double-ended free ring
    t_phys     rn_map [ARCH_REGS];
    t_phys     fl_ring [PHYS_REGS];
    t_ring_ptr fl_head;
    t_ring_ptr fl_tail;
    t_count    fl_count;

    t_rename_res res_q [$];      // expected results, oldest first
    t_inflight   inflight_q [$]; // renamed micro-ops still open
    t_dir_row    dir_tbl [$];

    logic no_idle = 1'b0;

    int err_cnt   = 0;
    int n_checked = 0;
    int n_rename  = 0;
    int n_short   = 0;
    int n_commit  = 0;
    int n_undo    = 0;
    int n_unused  = 0;
    int n_drop    = 0;

    register_rename_free_list_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_src1_valid     (i_src1_valid),
        .i_src1_arch      (i_src1_arch),
        .i_src2_valid     (i_src2_valid),
        .i_src2_arch      (i_src2_arch),
        .i_reads_flags    (i_reads_flags),
        .i_dest_valid     (i_dest_valid),
        .i_dest_arch      (i_dest_arch),
        .i_writes_flags   (i_writes_flags),
        .i_phys_a         (i_phys_a),
        .i_phys_b         (i_phys_b),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_phys_src1      (o_phys_src1),
        .o_phys_src2      (o_phys_src2),
        .o_phys_flags_src (o_phys_flags_src),
        .o_new_dest       (o_new_dest),
        .o_new_flags_dest (o_new_flags_dest),
        .o_prev_dest      (o_prev_dest),
        .o_prev_flags     (o_prev_flags),
        .o_status         (o_status),
        .o_free_count     (o_free_count)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic map_reset();
        for (int i = 0; i < ARCH_REGS; i++) rn_map[i] = t_phys'(i);
        // Slots past the initial free registers start out as zero
        for (int i = 0; i < PHYS_REGS; i++)
            fl_ring[i] = (i + ARCH_REGS < PHYS_REGS) ? t_phys'(i + ARCH_REGS) : '0;
        fl_head  = '0;
        fl_tail  = t_ring_ptr'(PHYS_REGS - ARCH_REGS);
        fl_count = t_count'(PHYS_REGS - ARCH_REGS);
    endtask

    // Take the register at the head of the free ring
    task automatic ring_take_head(output t_phys v);
        v        = fl_ring[fl_head];
        fl_head  = (fl_head == t_ring_ptr'(PHYS_REGS - 1)) ? '0 : fl_head + 1'b1;
        fl_count = fl_count - 1'b1;
    endtask

    // Return a squashed register to the head; drop it when the ring is full
    task automatic ring_give_head(input t_phys v);
        if (fl_count >= CNT_FULL) begin
            n_drop++;
        end else begin
            fl_head          = (fl_head == '0) ? t_ring_ptr'(PHYS_REGS - 1) : fl_head - 1'b1;
            fl_ring[fl_head] = v;
            fl_count         = fl_count + 1'b1;
        end
    endtask

    // Return a committed register to the tail; drop it when the ring is full
    task automatic ring_give_tail(input t_phys v);
        if (fl_count >= CNT_FULL) begin
            n_drop++;
        end else begin
            fl_ring[fl_tail] = v;
            fl_tail  = (fl_tail == t_ring_ptr'(PHYS_REGS - 1)) ? '0 : fl_tail + 1'b1;
            fl_count = fl_count + 1'b1;
        end
    endtask

    // Apply one micro-op to the predicted map and free ring, produce its result
    task automatic rename_predict(input t_uop u, output t_rename_res r);
        logic   dest_ok;
        t_count need;
        t_phys  cur;
        r       = '0;
        // An out-of-range destination counts as absent
        dest_ok = u.dv && (u.d < ARCH_LIMIT);
        case (u.func)
            FUNC_RENAME: begin
                n_rename++;
                need = t_count'(dest_ok) + t_count'(u.wf);
                // Sources are read before any destination is written
                if (u.s1v && u.s1 < ARCH_LIMIT) r.src1 = rn_map[u.s1];
                if (u.s2v && u.s2 < ARCH_LIMIT) r.src2 = rn_map[u.s2];
                if (u.rf) r.flags_src = rn_map[FLAGS_REG];
                if (fl_count < need) begin
                    r.status = STAT_SHORT;
                    n_short++;
                end else begin
                    // Destination first, so flags sees a fresh write to register 49
                    if (dest_ok) begin
                        ring_take_head(cur);
                        r.prev_dest = rn_map[u.d];
                        rn_map[u.d] = cur;
                        r.new_dest  = cur;
                    end
                    if (u.wf) begin
                        ring_take_head(cur);
                        r.prev_flags      = rn_map[FLAGS_REG];
                        rn_map[FLAGS_REG] = cur;
                        r.new_flags       = cur;
                    end
                end
            end
            FUNC_COMMIT: begin
                n_commit++;
                // An out-of-range destination also drops the first free
                if (dest_ok) ring_give_tail(u.pa);
                if (u.wf) ring_give_tail(u.pb);
            end
            FUNC_UNDO: begin
                n_undo++;
                // Restore happens even when the push gets dropped
                if (dest_ok) begin
                    cur         = rn_map[u.d];
                    rn_map[u.d] = u.pa;
                    ring_give_head(cur);
                end
                if (u.wf) begin
                    cur               = rn_map[FLAGS_REG];
                    rn_map[FLAGS_REG] = u.pb;
                    ring_give_head(cur);
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        r.free_cnt = fl_count;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic add_row(input t_dir_row row);
        dir_tbl.insert(dir_tbl.size(), row);
    endtask

    // Build one random micro-op; well-formed commits and undos replay open renames
    task automatic gen_uop(input int mode, output t_uop u);
        int        pick;
        int        p_ren;
        int        p_com;
        int        p_undo;
        t_inflight e;
        // Start from pure noise: every field, every bit, any function code
        u    = t_uop'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        case (mode)
            MODE_DRAIN: begin p_ren = 85; p_com = 5;  p_undo = 5;  end
            MODE_FILL:  begin p_ren = 8;  p_com = 82; p_undo = 5;  end
            default:    begin p_ren = 45; p_com = 30; p_undo = 15; end
        endcase
        if (pick < p_ren) begin
            u.func = FUNC_RENAME;
            u.s1   = t_arch'($urandom_range(0, ARCH_REGS - 1));
            u.s2   = t_arch'($urandom_range(0, ARCH_REGS - 1));
            u.d    = t_arch'($urandom_range(0, ARCH_REGS - 1));
            u.dv   = $urandom_range(0, 99) < ((mode == MODE_DRAIN) ? 95 : 70);
            u.wf   = $urandom_range(0, 99) < ((mode == MODE_DRAIN) ? 80 : 50);
        end else if (pick < p_ren + p_com) begin
            u.func = FUNC_COMMIT;
            if (inflight_q.size() != 0) begin
                // Free what the oldest open rename displaced
                e = inflight_q[0];
                inflight_q.delete(0);
                u.dv = e.dv;
                u.wf = e.wf;
                u.pa = e.prev_dest;
                u.pb = e.prev_flags;
            end else begin
                u.dv = 1'b1;
                u.wf = (mode == MODE_FILL) ? 1'b1 : u.wf;
            end
        end else if (pick < p_ren + p_com + p_undo) begin
            u.func = FUNC_UNDO;
            if (inflight_q.size() != 0) begin
                // Squash the youngest open rename
                e = inflight_q[inflight_q.size() - 1];
                inflight_q.delete(inflight_q.size() - 1);
                u.dv = e.dv;
                u.d  = e.d;
                u.wf = e.wf;
                u.pa = e.prev_dest;
                u.pb = e.prev_flags;
            end else begin
                u.d = t_arch'($urandom_range(0, ARCH_REGS - 1));
            end
        end
    endtask

    // Present one transaction, hold it until accepted, then record its expectation
    task automatic issue_uop(input t_uop u, input logic typed, input t_rename_res typed_res);
        t_rename_res r;
        t_inflight   e;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= u.func;
        i_src1_valid   <= u.s1v;
        i_src1_arch    <= u.s1;
        i_src2_valid   <= u.s2v;
        i_src2_arch    <= u.s2;
        i_reads_flags  <= u.rf;
        i_dest_valid   <= u.dv;
        i_dest_arch    <= u.d;
        i_writes_flags <= u.wf;
        i_phys_a       <= u.pa;
        i_phys_b       <= u.pb;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        rename_predict(u, r);
        res_q.insert(res_q.size(), typed ? typed_res : r);
        // Track completed renames so later commits and undos can replay them
        e.dv = u.dv && (u.d < ARCH_LIMIT);
        e.wf = u.wf;
        if (u.func == FUNC_RENAME && r.status == STAT_DONE && (e.dv || e.wf)) begin
            e.d          = u.d;
            e.prev_dest  = r.prev_dest;
            e.prev_flags = r.prev_flags;
            inflight_q.insert(inflight_q.size(), e);
            if (inflight_q.size() > MAX_INFLIGHT) inflight_q.delete(0);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
            note_failure($sformatf("result %0d field %s expected %0d got %0d",
                                   n_checked, name, want, got));
    endtask

    // Take each result when the output handshake completes; compare with the oldest expectation
    always @(posedge i_clk) begin
        t_rename_res got;
        t_rename_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_phys_src1, o_phys_src2, o_phys_flags_src, o_new_dest, o_new_flags_dest,
                    o_prev_dest, o_prev_flags, o_status, o_free_count};
            if (res_q.size() == 0) begin
                note_failure($sformatf("result with no transaction pending: %h", got));
            end else begin
                want = res_q[0];
                res_q.delete(0);
                check_field("phys_src1",      want.src1,       got.src1);
                check_field("phys_src2",      want.src2,       got.src2);
                check_field("phys_flags_src", want.flags_src,  got.flags_src);
                check_field("new_dest",       want.new_dest,   got.new_dest);
                check_field("new_flags_dest", want.new_flags,  got.new_flags);
                check_field("prev_dest",      want.prev_dest,  got.prev_dest);
                check_field("prev_flags",     want.prev_flags, got.prev_flags);
                check_field("status",         want.status,     got.status);
                check_field("free_count",     want.free_cnt,   got.free_cnt);
                n_checked++;
            end
        end
    end

    // Output backpressure: random stalls except during the quiet stretch
    always @(posedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_uop u;
        int   phase_mode [8];
        phase_mode = '{MODE_DRAIN, MODE_FILL, MODE_MIX, MODE_DRAIN,
                       MODE_MIX, MODE_FILL, MODE_DRAIN, MODE_FILL};

        // Drive every input to a known value from time zero
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_out_stall    <= 1'b0;
        i_func         <= FUNC_RENAME;
        i_src1_valid   <= 1'b0;
        i_src1_arch    <= '0;
        i_src2_valid   <= 1'b0;
        i_src2_arch    <= '0;
        i_reads_flags  <= 1'b0;
        i_dest_valid   <= 1'b0;
        i_dest_arch    <= '0;
        i_writes_flags <= 1'b0;
        i_phys_a       <= '0;
        i_phys_b       <= '0;
        map_reset();

        // Directed table. Fields: func, s1v, s1, s2v, s2, rf, dv, d, wf, pa, pb.
        // Fresh state: rename everything at once; free list hands out 50 then 51
        add_row('{'{FUNC_RENAME, 1'b1, 6'd0, 1'b1, 6'd48, 1'b1, 1'b1, 6'd0, 1'b1,
                    8'd0, 8'd0}, 1'b1,
                  '{8'd0, 8'd48, 8'd49, 8'd50, 8'd51, 8'd0, 8'd49, STAT_DONE, 9'd204}});
        // Out-of-range sources and destination read as absent
        add_row('{'{FUNC_RENAME, 1'b1, 6'd63, 1'b1, 6'd50, 1'b0, 1'b1, 6'd63, 1'b0,
                    8'd255, 8'd255}, 1'b1,
                  '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, STAT_DONE, 9'd204}});
        // Commit frees the two displaced registers; source fields are ignored
        add_row('{'{FUNC_COMMIT, 1'b1, 6'd5, 1'b1, 6'd7, 1'b1, 1'b1, 6'd0, 1'b1,
                    8'd0, 8'd49}, 1'b1,
                  '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, STAT_DONE, 9'd206}});
        // Unused function code changes nothing
        add_row('{'{FUNC_UNUSED, 1'b1, 6'd63, 1'b1, 6'd63, 1'b1, 1'b1, 6'd63, 1'b1,
                    8'd255, 8'd255}, 1'b1,
                  '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, STAT_DONE, 9'd206}});
        // Destination is the flags register and flags is written too
        add_row('{'{FUNC_RENAME, 1'b1, 6'd49, 1'b0, 6'd63, 1'b1, 1'b1, 6'd49, 1'b1,
                    8'd0, 8'd0}, 1'b0, NO_RES});
        // Undo the flags-on-flags rename
        add_row('{'{FUNC_UNDO, 1'b1, 6'd0, 1'b1, 6'd0, 1'b1, 1'b1, 6'd49, 1'b1,
                    8'd51, 8'd52}, 1'b0, NO_RES});
        // Undo with an out-of-range destination
        add_row('{'{FUNC_UNDO, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b1, 6'd50, 1'b0,
                    8'd7, 8'd0}, 1'b0, NO_RES});
        // Source valid low with a nonzero number
        add_row('{'{FUNC_RENAME, 1'b0, 6'd63, 1'b1, 6'd49, 1'b0, 1'b1, 6'd1, 1'b0,
                    8'd255, 8'd255}, 1'b0, NO_RES});
        // Commit single registers at the extremes
        add_row('{'{FUNC_COMMIT, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b1, 6'd0, 1'b0,
                    8'd255, 8'd0}, 1'b0, NO_RES});
        add_row('{'{FUNC_COMMIT, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0, 1'b1,
                    8'd255, 8'd0}, 1'b0, NO_RES});
        // Undo installs extreme physical numbers, rename reads them back
        add_row('{'{FUNC_UNDO, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b1, 6'd0, 1'b1,
                    8'd255, 8'd0}, 1'b0, NO_RES});
        add_row('{'{FUNC_RENAME, 1'b1, 6'd0, 1'b1, 6'd49, 1'b1, 1'b1, 6'd0, 1'b1,
                    8'd0, 8'd0}, 1'b0, NO_RES});
        // No destination and no flags write, for each function code
        add_row('{'{FUNC_RENAME, 1'b0, 6'd63, 1'b0, 6'd63, 1'b0, 1'b0, 6'd63, 1'b0,
                    8'd0, 8'd0}, 1'b0, NO_RES});
        add_row('{'{FUNC_UNUSED, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0, 1'b0,
                    8'd0, 8'd0}, 1'b0, NO_RES});
        add_row('{'{FUNC_COMMIT, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0, 6'd0, 1'b0,
                    8'd77, 8'd88}, 1'b0, NO_RES});
        add_row('{'{FUNC_UNDO, 1'b1, 6'd12, 1'b1, 6'd13, 1'b1, 1'b0, 6'd0, 1'b0,
                    8'd3, 8'd4}, 1'b0, NO_RES});
        // Highest non-flags register: rename then undo it
        add_row('{'{FUNC_RENAME, 1'b1, 6'd49, 1'b1, 6'd0, 1'b1, 1'b1, 6'd48, 1'b0,
                    8'd0, 8'd0}, 1'b0, NO_RES});
        add_row('{'{FUNC_UNDO, 1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b1, 6'd48, 1'b0,
                    8'd48, 8'd0}, 1'b0, NO_RES});

        // Hold reset, then release it once
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[i]) issue_uop(dir_tbl[i].op, dir_tbl[i].typed, dir_tbl[i].res);

        // Random phases: drain to a short free list, fill past full, mix in between
        for (int p = 0; p < 8; p++) begin
            no_idle = (p == QUIET_PHASE);
            for (int k = 0; k < PHASE_LEN; k++) begin
                gen_uop(phase_mode[p], u);
                issue_uop(u, 1'b0, NO_RES);
            end
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        // Drain: wait for every expected result, then let the pipeline settle
        while (res_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d transactions: %0d renames (%0d refused, free list short), %0d commits, %0d undos, %0d unused code.",
                 n_rename + n_commit + n_undo + n_unused, n_rename, n_short, n_commit, n_undo,
                 n_unused);
        $display("Checked %0d results, %0d frees dropped at a full list, %0d failures.",
                 n_checked, n_drop, err_cnt);
        if (err_cnt == 0) begin
            $display("register_rename_free_list_unit verification clean");
        end else begin
            $display("register_rename_free_list_unit verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout with %0d results still expected.", res_q.size());
        $display("register_rename_free_list_unit verification failed");
        $finish;
    end

endmodule

FILE: register_rename_free_list_unit.f
rtl/rrfl_pkg.sv
rtl/rrfl_ram.sv
rtl/register_rename_free_list_unit.sv
bench/register_rename_free_list_unit_tb.sv
